// File: hw/rtl/pcrel_pkg.sv
// Shared types, encodings and word helpers for the PC-relative relocator.
`timescale 1ns / 1ps

package pcrel_pkg;

	// Fixed words of the replacement runs
	localparam logic [31:0] NOP_WORD     = 32'hD503201F;
	localparam logic [31:0] LDR_X17_8    = 32'h58000051;
	localparam logic [31:0] B_12         = 32'h14000003;
	localparam logic [31:0] B_16         = 32'h14000004;
	localparam logic [31:0] B_24         = 32'h14000006;
	localparam logic [31:0] RET_X17      = 32'hD65F0220;
	localparam logic [31:0] ADR_X30_HERE = 32'h1000001E;
	localparam logic [31:0] ADD_X30_12   = 32'h910033DE;

	// Literal load of the address into the destination, offsets 8 and 16
	localparam logic [31:0] LDR_LIT_8    = 32'h58000040;
	localparam logic [31:0] LDR_LIT_16   = 32'h58000080;

	// Register-indirect loads that replace the literal forms
	localparam logic [31:0] LDR_W_IND    = 32'hB9400000;
	localparam logic [31:0] LDR_X_IND    = 32'hF9400000;
	localparam logic [31:0] LDRSW_IND    = 32'hB9800000;

	// Keep opcode, condition or register and bit number; offset field set to #8
	localparam logic [31:0] KEEP_COND    = 32'hFF00001F;
	localparam logic [31:0] KEEP_TB      = 32'hFFF8001F;
	localparam logic [31:0] OFFSET_8     = 32'h00000040;

	localparam int QUEUE_DEPTH = 2;
	localparam int IDX_W = 4;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [2:0] {
		KIND_COPY,
		KIND_B,
		KIND_BL,
		KIND_COND,
		KIND_ADR,
		KIND_LDR
	} kind_t;

	// One classified instruction waiting for expansion
	typedef struct packed {
		kind_t        kind;
		logic [31:0]  word0;
		logic [31:0]  word1;
		logic [63:0]  addr;
		idx_t         body_len;
		idx_t         last_idx;
	} item_t;

	// Word k of the absolute jump sequence through X17
	function automatic logic [31:0] jump_word(input idx_t k, input logic [63:0] addr);
		logic [31:0] w;
		case (k)
			4'd0:    w = LDR_X17_8;
			4'd1:    w = B_12;
			4'd2:    w = addr[31:0];
			4'd3:    w = addr[63:32];
			4'd4:    w = RET_X17;
			default: w = NOP_WORD;
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/pcrel_front.sv
// Front end: takes instruction words, classifies them and computes target addresses.
`timescale 1ns / 1ps

module pcrel_front #(
	parameter int PROLOGUE_SLOTS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [63:0]          base_q,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [2:0]           slot_index,
	input  logic [31:0]          instruction_word,
	input  logic                 q_full,
	output logic                 q_push,
	output pcrel_pkg::item_t     push_item
);
	import pcrel_pkg::*;

	localparam logic [31:0] LAST_SLOT = 32'(PROLOGUE_SLOTS - 1);

	logic        valid_s1;
	logic [2:0]  slot_s1;
	logic [31:0] word_s1;

	logic        accept;
	logic [31:0] w;
	logic [4:0]  rt;
	logic        is_b, is_bl, is_bc, is_adr, is_ldr, is_cb;
	logic [63:0] off;
	logic [63:0] sum;
	logic        has_tail;
	idx_t        body_len;
	logic [31:0] ld_op;
	kind_t       kind;
	logic [31:0] word0;
	logic [31:0] word1;
	logic [63:0] addr;
	idx_t        last_idx;

	assign item_stall = valid_s1 & q_full;
	assign accept = item_valid & ~item_stall;
	assign q_push = valid_s1 & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1 <= slot_index;
			word_s1 <= instruction_word;
		end
	end

	assign w  = word_s1;
	assign rt = w[4:0];

	assign is_b   = w[31:26] == 6'b000101;
	assign is_bl  = w[31:26] == 6'b100101;
	assign is_bc  = (w[31:24] == 8'h54) & ~w[4];
	assign is_adr = w[28:24] == 5'b10000;
	assign is_ldr = (w[31:24] == 8'h18) | (w[31:24] == 8'h58) | (w[31:24] == 8'h98);
	assign is_cb  = w[30:26] == 5'b01101;

	always_comb begin
		ld_op = LDRSW_IND;
		if (w[31:24] == 8'h18) begin
			ld_op = LDR_W_IND;
		end else if (w[31:24] == 8'h58) begin
			ld_op = LDR_X_IND;
		end
	end

	assign word1 = ld_op | {22'd0, rt, rt};

	// Classify and pick the sign-extended byte offset
	always_comb begin
		kind     = KIND_COPY;
		word0    = w;
		body_len = 4'd1;
		off      = {{43{w[23]}}, w[23:5], 2'b00};
		if (is_b | is_bl | is_bc) begin
			if (is_bc) begin
				kind     = KIND_COND;
				word0    = (w & KEEP_COND) | OFFSET_8;
				body_len = 4'd8;
			end else begin
				kind     = is_bl ? KIND_BL : KIND_B;
				off      = {{36{w[25]}}, w[25:0], 2'b00};
				body_len = is_bl ? 4'd8 : 4'd6;
			end
		end else if (is_adr) begin
			kind     = KIND_ADR;
			word0    = LDR_LIT_8 | {27'd0, rt};
			body_len = 4'd4;
			if (w[31]) begin
				off = {{31{w[23]}}, w[23:5], w[30:29], 12'h000};
			end else begin
				off = {{43{w[23]}}, w[23:5], w[30:29]};
			end
		end else if (is_ldr) begin
			kind     = KIND_LDR;
			word0    = LDR_LIT_16 | {27'd0, rt};
			body_len = 4'd6;
		end else if (is_cb) begin
			kind     = KIND_COND;
			body_len = 4'd8;
			if (w[25]) begin
				word0 = (w & KEEP_TB) | OFFSET_8;
				off   = {{48{w[18]}}, w[18:5], 2'b00};
			end else begin
				word0 = (w & KEEP_COND) | OFFSET_8;
			end
		end
	end

	assign sum = base_q + {59'd0, slot_s1, 2'b00} + off;
	assign has_tail = 32'(slot_s1) == LAST_SLOT;

	always_comb begin
		addr = sum;
		// ADRP drops the page offset
		if (is_adr & ~(is_b | is_bl | is_bc) & w[31]) begin
			addr = {sum[63:12], 12'h000};
		end
		last_idx = body_len - 4'd1 + (has_tail ? 4'd6 : 4'd0);
	end

	assign push_item = '{kind, word0, word1, addr, body_len, last_idx};

endmodule

// File: hw/rtl/pcrel_queue.sv
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps

module pcrel_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_push,
	input  pcrel_pkg::item_t     push_item,
	input  logic                 q_pop,
	output pcrel_pkg::item_t     head_item,
	output logic                 q_empty,
	output logic                 q_full
);
	import pcrel_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	item_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign q_empty   = count_q == '0;
	assign q_full    = count_q == (PTR_W + 1)'(QUEUE_DEPTH);
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({q_push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/pcrel_back.sv
// Back end: expands the head item into its run of words, one word per cycle unless the result side stalls.
`timescale 1ns / 1ps

module pcrel_back #(
	parameter int PROLOGUE_SLOTS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [63:0]          base_q,
	input  pcrel_pkg::item_t     head_item,
	input  logic                 q_empty,
	output logic                 q_pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [31:0]          output_word,
	output logic                 last_word
);
	import pcrel_pkg::*;

	localparam logic [63:0] TAIL_OFFSET = 64'(PROLOGUE_SLOTS * 4);

	idx_t        idx_q;
	logic        valid_q;
	logic [31:0] word_q;
	logic        last_q;

	logic        advance;
	logic        emit;
	logic        at_last;
	logic [63:0] tail_addr;
	logic [31:0] next_word;

	assign advance = ~valid_q | ~result_stall;
	assign emit    = advance & ~q_empty;
	assign at_last = idx_q == head_item.last_idx;
	assign q_pop   = emit & at_last;

	assign tail_addr = base_q + TAIL_OFFSET;

	always_comb begin
		next_word = NOP_WORD;
		if (idx_q >= head_item.body_len) begin
			next_word = jump_word(idx_q - head_item.body_len, tail_addr);
		end else begin
			case (head_item.kind)
				KIND_COPY: begin
					next_word = head_item.word0;
				end
				KIND_B: begin
					next_word = jump_word(idx_q, head_item.addr);
				end
				KIND_BL: begin
					case (idx_q)
						4'd4:    next_word = ADR_X30_HERE;
						4'd5:    next_word = ADD_X30_12;
						4'd6:    next_word = RET_X17;
						4'd7:    next_word = NOP_WORD;
						default: next_word = jump_word(idx_q, head_item.addr);
					endcase
				end
				KIND_COND: begin
					case (idx_q)
						4'd0:    next_word = head_item.word0;
						4'd1:    next_word = B_24;
						default: next_word = jump_word(idx_q - 4'd2, head_item.addr);
					endcase
				end
				KIND_ADR: begin
					if (idx_q == 4'd0) begin
						next_word = head_item.word0;
					end else begin
						next_word = jump_word(idx_q, head_item.addr);
					end
				end
				KIND_LDR: begin
					case (idx_q)
						4'd0:    next_word = head_item.word0;
						4'd1:    next_word = head_item.word1;
						4'd2:    next_word = B_16;
						4'd3:    next_word = NOP_WORD;
						4'd4:    next_word = head_item.addr[31:0];
						default: next_word = head_item.addr[63:32];
					endcase
				end
				default: begin
					next_word = head_item.word0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= ~q_empty;
			if (emit) begin
				idx_q <= at_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			word_q <= next_word;
			last_q <= at_last;
		end
	end

	assign result_valid = valid_q;
	assign output_word  = word_q;
	assign last_word    = last_q;

endmodule

// File: hw/rtl/arm64_pc_relative_relocator.sv
// Top level of the ARM64 PC-relative relocator: config register, front, queue, back.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------------
//   item     | item_valid / item_stall     | slot_index, instruction_word
//   result   | result_valid / result_stall | output_word, last_word
//   config   | base_address_we             | base_address
//
// Each item yields a run of 1 to 14 words; the back end sends one word per cycle
// while result_stall is low and the queue holds an item.
// The front end takes a new item every cycle while the two-entry queue has room;
// each item passes the front register and the queue before the back end registers its words.
// Reset clears all valids and sets the base register to zero.
// A stall on the result side holds the output word; the front keeps filling the queue.
`timescale 1ns / 1ps

module arm64_pc_relative_relocator #(
	parameter int PROLOGUE_SLOTS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        base_address_we,
	input  logic [63:0] base_address,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  slot_index,
	input  logic [31:0] instruction_word,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] output_word,
	output logic        last_word
);
	import pcrel_pkg::*;

	logic [63:0] base_q;
	logic        q_push;
	logic        q_pop;
	logic        q_empty;
	logic        q_full;
	item_t       push_item;
	item_t       head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (base_address_we) begin
			base_q <= base_address;
		end
	end

	pcrel_front #(
		.PROLOGUE_SLOTS(PROLOGUE_SLOTS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.base_q           (base_q),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.slot_index       (slot_index),
		.instruction_word (instruction_word),
		.q_full           (q_full),
		.q_push           (q_push),
		.push_item        (push_item)
	);

	pcrel_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_push    (q_push),
		.push_item (push_item),
		.q_pop     (q_pop),
		.head_item (head_item),
		.q_empty   (q_empty),
		.q_full    (q_full)
	);

	pcrel_back #(
		.PROLOGUE_SLOTS(PROLOGUE_SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.base_q       (base_q),
		.head_item    (head_item),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.output_word  (output_word),
		.last_word    (last_word)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue pop while empty");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> q_full)
		else $error("input stalled with room in the queue");

	a_last_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$past(q_pop) |-> result_valid && last_word)
		else $error("run end not marked on the output");

endmodule

// File: test/arm64_pc_relative_relocator_tb.sv
// Self-checking testbench for the ARM64 PC-relative relocator: directed table, then random runs.
`timescale 1ns / 1ps

module arm64_pc_relative_relocator_tb;
	import pcrel_pkg::*;

	localparam int PROLOGUE_SLOTS = 6;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int HOLD_CYCLES    = 200;
	localparam int SETTLE_CYCLES  = 6;
	localparam int RANDOM_ITEMS   = 25;
	localparam int DIR_ROWS       = 25;

	// Opcode fields used to classify and build instructions
	localparam logic [31:0] BTI_C        = 32'hD503245F;
	localparam logic [31:0] BTI_J        = 32'hD503249F;
	localparam logic [31:0] BTI_JC       = 32'hD50324DF;
	localparam logic [5:0]  OP_B         = 6'b000101;
	localparam logic [5:0]  OP_BL        = 6'b100101;
	localparam logic [7:0]  OP_BCOND     = 8'h54;
	localparam logic [4:0]  ADR_FAMILY   = 5'b10000;
	localparam logic [7:0]  LIT_W_TOP    = 8'h18;
	localparam logic [7:0]  LIT_X_TOP    = 8'h58;
	localparam logic [7:0]  LIT_SW_TOP   = 8'h98;
	localparam logic [4:0]  CMP_TB_FAMILY = 5'b01101;

	typedef enum int {
		GEN_BTI,
		GEN_B,
		GEN_BL,
		GEN_BCOND,
		GEN_ADR,
		GEN_LIT,
		GEN_CBTB,
		GEN_RAW
	} gen_kind_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [2:0]  slot;
		logic [31:0] insn;
		logic        typed;
		logic [31:0] typed_word;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        base_address_we;
	logic [63:0] base_address;
	logic        item_valid;
	logic        item_stall;
	logic [2:0]  slot_index;
	logic [31:0] instruction_word;
	logic        result_valid;
	logic        result_stall;
	logic [31:0] output_word;
	logic        last_word;

	logic [63:0] base_model;
	out_word_t   pending_words[$];
	logic [31:0] run_words [0:13];
	int          run_len;

	int  errors;
	int  items_sent;
	int  words_checked;
	int  base_settings;
	int  cycles;
	int  burst_left;
	bit  steady_send;
	bit  hold_req;
	int  hold_done;

	// Copies are typed in; everything else goes through the predictor
	dir_row_t directed_rows [0:DIR_ROWS-1] = '{
		'{3'd0, 32'hD503245F, 1'b1, 32'hD503245F},
		'{3'd1, 32'hD503249F, 1'b1, 32'hD503249F},
		'{3'd2, 32'hD50324DF, 1'b1, 32'hD50324DF},
		'{3'd3, 32'h00000000, 1'b1, 32'h00000000},
		'{3'd4, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
		'{3'd0, 32'h14000001, 1'b0, 32'h0},
		'{3'd1, 32'h16000000, 1'b0, 32'h0},
		'{3'd2, 32'h15FFFFFF, 1'b0, 32'h0},
		'{3'd3, 32'h94000010, 1'b0, 32'h0},
		'{3'd4, 32'h54000040, 1'b0, 32'h0},
		'{3'd0, 32'h54FFFFEF, 1'b0, 32'h0},
		'{3'd1, 32'h10000003, 1'b0, 32'h0},
		'{3'd2, 32'h70FFFFE4, 1'b0, 32'h0},
		'{3'd3, 32'hF0FFFFE5, 1'b0, 32'h0},
		'{3'd4, 32'h90000006, 1'b0, 32'h0},
		'{3'd0, 32'h18000007, 1'b0, 32'h0},
		'{3'd1, 32'h58FFFFE8, 1'b0, 32'h0},
		'{3'd2, 32'h980000E9, 1'b0, 32'h0},
		'{3'd3, 32'h3400008A, 1'b0, 32'h0},
		'{3'd4, 32'hB5FFFFEB, 1'b0, 32'h0},
		'{3'd0, 32'h36F8006C, 1'b0, 32'h0},
		'{3'd1, 32'hB7FFFFED, 1'b0, 32'h0},
		'{3'd6, 32'h1C000001, 1'b1, 32'h1C000001},
		'{3'd7, 32'hD8000002, 1'b1, 32'hD8000002},
		'{3'd5, 32'h97FFFFFF, 1'b0, 32'h0}
	};

	arm64_pc_relative_relocator #(
		.PROLOGUE_SLOTS(PROLOGUE_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.base_address_we(base_address_we),
		.base_address(base_address),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.slot_index(slot_index),
		.instruction_word(instruction_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.output_word(output_word),
		.last_word(last_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void emit(input logic [31:0] x);
		run_words[run_len] = x;
		run_len++;
	endfunction

	function automatic void emit_jump(input logic [63:0] target);
		emit(LDR_X17_8);
		emit(B_12);
		emit(target[31:0]);
		emit(target[63:32]);
	endfunction

	// Build the relocated run for one instruction and queue its words
	function automatic void predict_run(input logic [63:0] base, input logic [2:0] slot,
			input logic [31:0] w);
		logic [63:0] pc;
		logic [63:0] target;
		logic [31:0] rt;
		logic [31:0] ld;
		bit          is_bcond;
		pc = base + {59'd0, slot, 2'b00};
		rt = {27'd0, w[4:0]};
		is_bcond = (w[31:24] == OP_BCOND) && !w[4];
		run_len = 0;
		if (w == BTI_C || w == BTI_J || w == BTI_JC) begin
			emit(w);
		end else if (w[31:26] == OP_B || w[31:26] == OP_BL || is_bcond) begin
			if (is_bcond) begin
				target = pc + {{43{w[23]}}, w[23:5], 2'b00};
				emit((w & KEEP_COND) | OFFSET_8);
				emit(B_24);
			end else begin
				target = pc + {{36{w[25]}}, w[25:0], 2'b00};
			end
			emit_jump(target);
			if (w[31:26] == OP_BL) begin
				emit(ADR_X30_HERE);
				emit(ADD_X30_12);
			end
			emit(RET_X17);
			emit(NOP_WORD);
		end else if (w[28:24] == ADR_FAMILY) begin
			// ADRP rounds down to the page after adding
			if (w[31])
				target = (pc + {{31{w[23]}}, w[23:5], w[30:29], 12'd0}) & ~64'hFFF;
			else
				target = pc + {{43{w[23]}}, w[23:5], w[30:29]};
			emit(LDR_LIT_8 | rt);
			emit(B_12);
			emit(target[31:0]);
			emit(target[63:32]);
		end else if (w[31:24] == LIT_W_TOP || w[31:24] == LIT_X_TOP || w[31:24] == LIT_SW_TOP) begin
			target = pc + {{43{w[23]}}, w[23:5], 2'b00};
			if (w[31:24] == LIT_W_TOP)
				ld = LDR_W_IND;
			else if (w[31:24] == LIT_X_TOP)
				ld = LDR_X_IND;
			else
				ld = LDRSW_IND;
			emit(LDR_LIT_16 | rt);
			emit(ld | rt | (rt << 5));
			emit(B_16);
			emit(NOP_WORD);
			emit(target[31:0]);
			emit(target[63:32]);
		end else if (w[30:26] == CMP_TB_FAMILY) begin
			if (w[25]) begin
				target = pc + {{48{w[18]}}, w[18:5], 2'b00};
				emit((w & KEEP_TB) | OFFSET_8);
			end else begin
				target = pc + {{43{w[23]}}, w[23:5], 2'b00};
				emit((w & KEEP_COND) | OFFSET_8);
			end
			emit(B_24);
			emit_jump(target);
			emit(RET_X17);
			emit(NOP_WORD);
		end else begin
			emit(w);
		end
		if (int'(slot) == PROLOGUE_SLOTS - 1) begin
			emit_jump(base + 64'(PROLOGUE_SLOTS * 4));
			emit(RET_X17);
			emit(NOP_WORD);
		end
		for (int i = 0; i < run_len; i++)
			pending_words.push_back('{run_words[i], i == run_len - 1});
	endfunction

	function automatic logic [31:0] make_insn(input gen_kind_t k);
		logic [31:0] r;
		logic [31:0] w;
		r = $urandom;
		case (k)
			GEN_BTI: begin
				case ($urandom_range(0, 2))
					0:       w = BTI_C;
					1:       w = BTI_J;
					default: w = BTI_JC;
				endcase
			end
			GEN_B:     w = {OP_B, r[25:0]};
			GEN_BL:    w = {OP_BL, r[25:0]};
			GEN_BCOND: w = {OP_BCOND, r[23:5], 1'b0, r[3:0]};
			GEN_ADR:   w = {r[31:29], ADR_FAMILY, r[23:0]};
			GEN_LIT: begin
				case ($urandom_range(0, 2))
					0:       w = {LIT_W_TOP, r[23:0]};
					1:       w = {LIT_X_TOP, r[23:0]};
					default: w = {LIT_SW_TOP, r[23:0]};
				endcase
			end
			GEN_CBTB:  w = {r[31], CMP_TB_FAMILY, r[25:0]};
			default:   w = r;
		endcase
		return w;
	endfunction

	// Offer one word on the input; returns at the edge that accepts it
	task automatic send_item(input logic [2:0] s, input logic [31:0] w,
			input logic typed, input logic [31:0] typed_word);
		if (!steady_send) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left--;
		end
		item_valid <= 1'b1;
		slot_index <= s;
		instruction_word <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (typed)
			pending_words.push_back('{typed_word, 1'b1});
		else
			predict_run(base_model, s, w);
		items_sent++;
	endtask

	task automatic set_base(input logic [63:0] value);
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		base_address_we <= 1'b1;
		base_address <= value;
		@(posedge clk);
		base_address_we <= 1'b0;
		base_model = value;
		base_settings++;
	endtask

	// Mostly in-order prologue sequences, with some stray slots mixed in
	task automatic run_random(input int n);
		int          seq_pos;
		logic [2:0]  s;
		logic [31:0] w;
		seq_pos = 0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) != 0) begin
				s = seq_pos[2:0];
				seq_pos = (seq_pos + 1) % PROLOGUE_SLOTS;
			end else begin
				s = 3'($urandom_range(0, 7));
			end
			w = make_insn(gen_kind_t'($urandom_range(0, GEN_RAW)));
			send_item(s, w, 1'b0, 32'h0);
		end
		item_valid <= 1'b0;
	endtask

	// Output side: stall patterns, plus one long hold-off on request
	initial begin : output_side
		int mode;
		int mode_left;
		int tick;
		mode = 0;
		mode_left = 0;
		tick = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
				hold_req = 1'b0;
				hold_done++;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(10, 60);
				end
				mode_left--;
				case (mode)
					0:       result_stall <= 1'b0;
					1:       result_stall <= ($urandom_range(0, 2) == 0);
					default: result_stall <= (tick % 3 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_words
		out_word_t head;
		if (arst_n && result_valid && !result_stall) begin
			words_checked++;
			if (pending_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, actual %h last %b",
					$time, output_word, last_word);
			end else begin
				head = pending_words.pop_front();
				if (output_word !== head.word) begin
					errors++;
					$display("%0t: output_word mismatch: expected %h, actual %h",
						$time, head.word, output_word);
				end
				if (last_word !== head.last) begin
					errors++;
					$display("%0t: last_word mismatch: expected %b, actual %b",
						$time, head.last, last_word);
				end
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout after %0d cycles, %0d words still expected",
			$time, cycles, pending_words.size());
		$display("TB_ERROR");
		$finish;
	end

	initial begin : main
		arst_n = 1'b0;
		base_address_we = 1'b0;
		base_address = 64'd0;
		item_valid = 1'b0;
		slot_index = 3'd0;
		instruction_word = 32'd0;
		base_model = 64'd0;
		errors = 0;
		items_sent = 0;
		words_checked = 0;
		base_settings = 0;
		burst_left = 0;
		steady_send = 1'b0;
		hold_req = 1'b0;
		hold_done = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows run at the reset value of the base
		for (int i = 0; i < DIR_ROWS; i++)
			send_item(directed_rows[i].slot, directed_rows[i].insn,
				directed_rows[i].typed, directed_rows[i].typed_word);
		item_valid <= 1'b0;

		set_base(64'hFFFF_FFFF_FFFF_FFFF);
		run_random(RANDOM_ITEMS);

		// Hold the output for a long stretch while the input keeps pushing
		set_base({$urandom, $urandom});
		steady_send = 1'b1;
		hold_req = 1'b1;
		run_random(RANDOM_ITEMS);
		steady_send = 1'b0;

		set_base(64'h0000_0000_FFFF_FFF0);
		run_random(RANDOM_ITEMS);

		set_base(64'h8000_0000_0000_0000);
		steady_send = 1'b1;
		run_random(RANDOM_ITEMS);
		steady_send = 1'b0;

		set_base(64'd0);
		run_random(RANDOM_ITEMS);

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Relocated %0d instructions (%0d directed) into %0d checked words",
			items_sent, DIR_ROWS, words_checked);
		$display("over %0d written base addresses, %0d long output hold-off(s), %0d errors",
			base_settings, hold_done, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/pcrel_pkg.sv
hw/rtl/pcrel_front.sv
hw/rtl/pcrel_queue.sv
hw/rtl/pcrel_back.sv
hw/rtl/arm64_pc_relative_relocator.sv
test/arm64_pc_relative_relocator_tb.sv
